### hdl/lgte_pkg.sv
// Shared types and constants for the logic gate tile evaluator.
// Used by lgte_eval, the core top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package lgte_pkg;

  // Four-valued tile state encoding
  localparam logic [1:0] ST_OFF  = 2'd0;
  localparam logic [1:0] ST_LOW  = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;
  localparam logic [1:0] ST_MID  = 2'd3;

  // Gate kinds; codes 9 to 15 are unused and leave the pending state alone
  typedef enum logic [3:0] {
    GATE_DIODE  = 4'd0,
    GATE_BUFFER = 4'd1,
    GATE_NOT    = 4'd2,
    GATE_AND    = 4'd3,
    GATE_NAND   = 4'd4,
    GATE_OR     = 4'd5,
    GATE_NOR    = 4'd6,
    GATE_XOR    = 4'd7,
    GATE_XNOR   = 4'd8
  } gate_kind_e;

  // Transaction function carried in tuser
  typedef enum logic {
    FUNC_EVAL   = 1'b0,
    FUNC_COMMIT = 1'b1
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GATE_KIND   = 2'd0,
    CFG_OUTPUT_SIDE = 2'd1,
    CFG_EXTRA_ON    = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef struct packed {
    logic [3:0] gate_kind;
    logic [1:0] output_side;
    logic       extra_states_on;
  } cfg_t;

endpackage

### hdl/lgte_eval.sv
// Combinational next-state evaluation for one tile from its four neighbors.
// Depends on lgte_pkg for the state encoding, gate kinds and the config struct.
`timescale 1ns / 1ps

module lgte_eval (
  input  lgte_pkg::cfg_t   cfg_i,
  input  logic [3:0][1:0]  nbr_i,      // north, east, south, west
  input  logic [1:0]       pending_i,
  output logic [1:0]       next_o
);

  logic [2:0] n_cnt;
  logic [2:0] hi_cnt;
  logic [2:0] mid_cnt;
  logic [1:0] data_st;
  logic [1:0] ctl_st;
  logic [1:0] diode_st;
  logic [1:0] buf_st;
  logic [1:0] and_st;
  logic [1:0] or_st;
  logic [1:0] xor_st;

  function automatic logic [1:0] complement(input logic [1:0] s);
    logic [1:0] r;
    r = s;
    if (s == lgte_pkg::ST_LOW) begin
      r = lgte_pkg::ST_HIGH;
    end else if (s == lgte_pkg::ST_HIGH) begin
      r = lgte_pkg::ST_LOW;
    end
    return r;
  endfunction

  // Count connected, high and middle inputs, skipping the output side
  always_comb begin
    n_cnt   = '0;
    hi_cnt  = '0;
    mid_cnt = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) != cfg_i.output_side && nbr_i[i] != lgte_pkg::ST_OFF) begin
        n_cnt = n_cnt + 3'd1;
        if (nbr_i[i] == lgte_pkg::ST_HIGH) begin
          hi_cnt = hi_cnt + 3'd1;
        end else if (nbr_i[i] == lgte_pkg::ST_MID) begin
          mid_cnt = mid_cnt + 3'd1;
        end
      end
    end
    if (!cfg_i.extra_states_on) begin
      mid_cnt = '0;
    end
  end

  // Tri-state data comes from the far side, control from either flank
  always_comb begin
    data_st = nbr_i[cfg_i.output_side + 2'd2];
    ctl_st  = nbr_i[cfg_i.output_side + 2'd1];
    if (ctl_st == lgte_pkg::ST_OFF) begin
      ctl_st = nbr_i[cfg_i.output_side + 2'd3];
    end
  end

  always_comb begin
    diode_st = lgte_pkg::ST_LOW;
    if (n_cnt == 3'd1 && hi_cnt == 3'd1) begin
      diode_st = lgte_pkg::ST_HIGH;
    end else if (n_cnt == 3'd1 && mid_cnt == 3'd1) begin
      diode_st = lgte_pkg::ST_MID;
    end

    buf_st = lgte_pkg::ST_LOW;
    if (n_cnt == 3'd1) begin
      buf_st = diode_st;
    end else if (n_cnt == 3'd2 && cfg_i.extra_states_on &&
                 data_st != lgte_pkg::ST_OFF) begin
      buf_st = (ctl_st == lgte_pkg::ST_HIGH) ? data_st : lgte_pkg::ST_MID;
    end

    and_st = lgte_pkg::ST_LOW;
    or_st  = lgte_pkg::ST_LOW;
    xor_st = lgte_pkg::ST_LOW;
    if (n_cnt >= 3'd2) begin
      if (hi_cnt == n_cnt) begin
        and_st = lgte_pkg::ST_HIGH;
      end else if (hi_cnt + mid_cnt == n_cnt) begin
        and_st = lgte_pkg::ST_MID;
      end

      if (hi_cnt != 3'd0) begin
        or_st = lgte_pkg::ST_HIGH;
      end else if (mid_cnt != 3'd0) begin
        or_st = lgte_pkg::ST_MID;
      end

      if (mid_cnt != 3'd0) begin
        xor_st = lgte_pkg::ST_MID;
      end else if (hi_cnt[0]) begin
        xor_st = lgte_pkg::ST_HIGH;
      end
    end
  end

  always_comb begin
    unique case (cfg_i.gate_kind)
      lgte_pkg::GATE_DIODE:  next_o = diode_st;
      lgte_pkg::GATE_BUFFER: next_o = buf_st;
      lgte_pkg::GATE_NOT:    next_o = complement(buf_st);
      lgte_pkg::GATE_AND:    next_o = and_st;
      lgte_pkg::GATE_NAND:   next_o = complement(and_st);
      lgte_pkg::GATE_OR:     next_o = or_st;
      lgte_pkg::GATE_NOR:    next_o = complement(or_st);
      lgte_pkg::GATE_XOR:    next_o = xor_st;
      lgte_pkg::GATE_XNOR:   next_o = complement(xor_st);
      default:               next_o = pending_i;
    endcase
  end

endmodule

### hdl/logic_gate_tile_evaluator_core.sv
// Each accepted result is registered in the result register, or in the skid register
// while an older result waits. Throughput: one transaction per cycle while the skid
// register is empty; the gate is evaluated in a single pass before the result register.
// Reset: rst_ni low clears the config registers to zero, sets current and pending
// state to low and empties the result and skid registers.
// Top level of the logic gate tile evaluator; instantiates lgte_eval, uses lgte_pkg.
`timescale 1ns / 1ps

module logic_gate_tile_evaluator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lgte_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lgte_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [1:0] north_in, [3:2] east_in, [5:4] south_in, [7:6] west_in
  input  logic [7:0]                    s_axis_tdata_i,
  // [0] func
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [1:0] next_value, [2] will_change, [4:3] driven_value, [7:5] zero
  output logic [7:0]                    m_axis_tdata_o
);

  lgte_pkg::cfg_t cfg_q;
  logic [1:0]     cur_q, pend_q;
  logic [1:0]     eval_next;
  logic [1:0]     res_next, res_cur;
  logic [4:0]     res_d;
  logic [4:0]     out_q, skid_q;
  logic           out_vld_q, skid_vld_q;
  logic           s_take, m_take;

  assign s_axis_tready_o = !skid_vld_q;
  assign s_take = s_axis_tvalid_i && s_axis_tready_o;
  assign m_take = out_vld_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lgte_pkg::CFG_GATE_KIND:   cfg_q.gate_kind       <= cfg_wdata_i;
        lgte_pkg::CFG_OUTPUT_SIDE: cfg_q.output_side     <= cfg_wdata_i[1:0];
        lgte_pkg::CFG_EXTRA_ON:    cfg_q.extra_states_on <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  lgte_eval u_eval (
    .cfg_i     (cfg_q),
    .nbr_i     (s_axis_tdata_i),
    .pending_i (pend_q),
    .next_o    (eval_next)
  );

  always_comb begin
    if (s_axis_tuser_i == lgte_pkg::FUNC_COMMIT) begin
      res_next = pend_q;
      res_cur  = pend_q;
    end else begin
      res_next = eval_next;
      res_cur  = cur_q;
    end
    res_d = {res_cur, res_next != res_cur, res_next};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= lgte_pkg::ST_LOW;
      pend_q <= lgte_pkg::ST_LOW;
    end else if (s_take) begin
      cur_q  <= res_cur;
      pend_q <= res_next;
    end
  end

  // Result register with a skid stage: park a new result while the old one waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (s_take) begin
      if (!out_vld_q || m_take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (m_take) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      if (!out_vld_q || m_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (m_take && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

endmodule

### hdl/lgte_checker.sv
// Port-level checker for the logic gate tile evaluator core, bound to the top level.
// Depends on lgte_pkg for the state encoding.
`timescale 1ns / 1ps

module lgte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // The change flag must agree with the two reported states
  a_change_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[2] == (m_axis_tdata_o[1:0] != m_axis_tdata_o[4:3]))
    else $error("will_change disagrees with next and driven values");

  // Neither reported state is ever the disconnected code
  a_states_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[1:0] != lgte_pkg::ST_OFF && m_axis_tdata_o[4:3] != lgte_pkg::ST_OFF))
    else $error("result carries a disconnected state");

  // Back pressure upstream only when a result is already waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind logic_gate_tile_evaluator_core lgte_checker u_lgte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for logic_gate_tile_evaluator_core: neighbor-state stream in,
// gate result stream out, checked against a behavioral tile model. Needs lgte_pkg.

module testbench;

  localparam logic [3:0] GATE_UNUSED_MAX = 4'hF;
  localparam logic [1:0] SIDE_NORTH = 2'd0;
  localparam logic [1:0] SIDE_EAST  = 2'd1;
  localparam logic [1:0] SIDE_SOUTH = 2'd2;
  localparam logic [1:0] SIDE_WEST  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  // Same layout as m_axis_tdata_o[4:0]
  typedef struct packed {
    logic [1:0] driven;
    logic       change;
    logic [1:0] next;
  } tile_result_t;

  class tile_scoreboard;
    logic [3:0]   gate_kind;
    logic [1:0]   out_side;
    logic         extra_on;
    logic [1:0]   cur_state;
    logic [1:0]   next_state;
    tile_result_t expected_q[$];
    int unsigned  n_in;
    int unsigned  n_out;
    int unsigned  n_err;

    function new();
      gate_kind  = lgte_pkg::GATE_DIODE;
      out_side   = SIDE_NORTH;
      extra_on   = 1'b0;
      cur_state  = lgte_pkg::ST_LOW;
      next_state = lgte_pkg::ST_LOW;
      n_in  = 0;
      n_out = 0;
      n_err = 0;
    endfunction

    function void set_config(logic [3:0] kind, logic [1:0] side, logic extra);
      gate_kind = kind;
      out_side  = side;
      extra_on  = extra;
    endfunction

    function logic [1:0] flip(logic [1:0] s);
      if (s == lgte_pkg::ST_LOW) return lgte_pkg::ST_HIGH;
      if (s == lgte_pkg::ST_HIGH) return lgte_pkg::ST_LOW;
      return s;
    endfunction

    // Buffer with the tri-state form: two inputs, data opposite the output, side control
    function logic [1:0] buffer_out(logic [1:0] adj[4], int n, int hi, int mid);
      logic [1:0] data;
      logic [1:0] ctl;
      data = adj[out_side + 2'd2];
      ctl  = adj[out_side + 2'd1];
      if (n == 1) begin
        if (hi == 1) return lgte_pkg::ST_HIGH;
        if (mid == 1) return lgte_pkg::ST_MID;
      end else if (n == 2 && extra_on && data != lgte_pkg::ST_OFF) begin
        if (ctl == lgte_pkg::ST_OFF) ctl = adj[out_side + 2'd3];
        return (ctl == lgte_pkg::ST_HIGH) ? data : lgte_pkg::ST_MID;
      end
      return lgte_pkg::ST_LOW;
    endfunction

    function void evaluate(logic [7:0] nbr);
      logic [1:0] adj[4];
      logic [1:0] and_v;
      logic [1:0] or_v;
      logic [1:0] xor_v;
      int n;
      int hi;
      int mid;
      n = 0;
      hi = 0;
      mid = 0;
      for (int i = 0; i < 4; i++) begin
        adj[i] = nbr[2*i +: 2];
        if (i != out_side && adj[i] != lgte_pkg::ST_OFF) begin
          n++;
          if (adj[i] == lgte_pkg::ST_HIGH) hi++;
          else if (adj[i] == lgte_pkg::ST_MID) mid++;
        end
      end
      // middle reads as low unless the extra states are on
      if (!extra_on) mid = 0;
      and_v = (n >= 2 && hi == n) ? lgte_pkg::ST_HIGH :
              (n >= 2 && hi + mid == n) ? lgte_pkg::ST_MID : lgte_pkg::ST_LOW;
      or_v  = (n >= 2 && hi >= 1) ? lgte_pkg::ST_HIGH :
              (n >= 2 && mid >= 1) ? lgte_pkg::ST_MID : lgte_pkg::ST_LOW;
      xor_v = (n >= 2 && mid != 0) ? lgte_pkg::ST_MID :
              (n >= 2 && hi % 2 == 1) ? lgte_pkg::ST_HIGH : lgte_pkg::ST_LOW;
      case (gate_kind)
        lgte_pkg::GATE_DIODE:  next_state = (n == 1 && hi == 1) ? lgte_pkg::ST_HIGH :
                                            (n == 1 && mid == 1) ? lgte_pkg::ST_MID :
                                            lgte_pkg::ST_LOW;
        lgte_pkg::GATE_BUFFER: next_state = buffer_out(adj, n, hi, mid);
        lgte_pkg::GATE_NOT:    next_state = flip(buffer_out(adj, n, hi, mid));
        lgte_pkg::GATE_AND:    next_state = and_v;
        lgte_pkg::GATE_NAND:   next_state = flip(and_v);
        lgte_pkg::GATE_OR:     next_state = or_v;
        lgte_pkg::GATE_NOR:    next_state = flip(or_v);
        lgte_pkg::GATE_XOR:    next_state = xor_v;
        lgte_pkg::GATE_XNOR:   next_state = flip(xor_v);
        default: ;  // unused kinds keep the pending state
      endcase
    endfunction

    function void note_input(lgte_pkg::func_e f, logic [7:0] nbr);
      tile_result_t r;
      if (f == lgte_pkg::FUNC_COMMIT) cur_state = next_state;
      else evaluate(nbr);
      r.next   = next_state;
      r.change = (next_state != cur_state);
      r.driven = cur_state;
      expected_q = {expected_q, r};
      n_in++;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on result %0d, %s: got %0d, want %0d",
               $realtime, n_out, what, got, want);
      n_err++;
    endtask

    task check_result(logic [7:0] tdata);
      tile_result_t got;
      tile_result_t want;
      got = tile_result_t'(tdata[4:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", tdata, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.next != want.next) report_mismatch("next_value", got.next, want.next);
        if (got.change != want.change)
          report_mismatch("will_change", got.change, want.change);
        if (got.driven != want.driven)
          report_mismatch("driven_value", got.driven, want.driven);
        if (tdata[7:5] != 3'b000) report_mismatch("pad bits", tdata[7:5], 0);
      end
      n_out++;
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [lgte_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lgte_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;
  logic       s_axis_tuser_i;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;

  tile_scoreboard sb = new();
  int unsigned burst_left;
  int unsigned n_cfg;
  int unsigned n_stall;
  bit          hold_req;

  logic_gate_tile_evaluator_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check results before noting inputs: a result never belongs to the same edge's input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_input(lgte_pkg::func_e'(s_axis_tuser_i), s_axis_tdata_i);
      if (s_axis_tvalid_i && !s_axis_tready_o) n_stall++;
    end
  end

  // Downstream side: switches between stall patterns, plus a long hold-off on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cyc;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(RX_OPEN, RX_PERIODIC));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_axis_tready_i <= 1'b1;
          RX_RANDOM: m_axis_tready_i <= ($urandom_range(0, 99) < 55);
          default:   m_axis_tready_i <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL logic_gate_tile_evaluator_core");
    $finish;
  end

  function automatic logic [7:0] pack_nbr(logic [1:0] n, logic [1:0] e,
                                          logic [1:0] s, logic [1:0] w);
    return {w, s, e, n};
  endfunction

  // Offer one transaction; bursts end in a random gap
  task automatic send_item(lgte_pkg::func_e f, logic [7:0] nbr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= f;
    s_axis_tdata_i  <= nbr;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_config(logic [3:0] kind, logic [1:0] side, logic extra);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= lgte_pkg::CFG_GATE_KIND;
    cfg_wdata_i <= kind;
    @(posedge clk_i);
    cfg_idx_i   <= lgte_pkg::CFG_OUTPUT_SIDE;
    cfg_wdata_i <= {2'b00, side};
    @(posedge clk_i);
    cfg_idx_i   <= lgte_pkg::CFG_EXTRA_ON;
    cfg_wdata_i <= {3'b000, extra};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(kind, side, extra);
    n_cfg++;
  endtask

  task automatic run_random(int unsigned count);
    logic [1:0] adj[4];
    logic [1:0] side;
    for (int unsigned i = 0; i < count; i++) begin
      side = sb.out_side;
      if ($urandom_range(0, 3) == 0) begin
        send_item(lgte_pkg::FUNC_COMMIT, 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 2) == 0) begin
        // tri-state shape: data opposite the output, one side control, other side open
        adj[side] = 2'($urandom_range(lgte_pkg::ST_OFF, lgte_pkg::ST_MID));
        adj[side + 2'd2] = 2'($urandom_range(lgte_pkg::ST_LOW, lgte_pkg::ST_MID));
        adj[side + 2'd1] = 2'($urandom_range(lgte_pkg::ST_LOW, lgte_pkg::ST_MID));
        adj[side + 2'd3] = lgte_pkg::ST_OFF;
        if ($urandom_range(0, 1) == 1) begin
          adj[side + 2'd3] = adj[side + 2'd1];
          adj[side + 2'd1] = lgte_pkg::ST_OFF;
        end
        send_item(lgte_pkg::FUNC_EVAL, pack_nbr(adj[0], adj[1], adj[2], adj[3]));
      end else begin
        send_item(lgte_pkg::FUNC_EVAL, 8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [3:0] kind;
    rst_ni          = 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= lgte_pkg::CFG_GATE_KIND;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= lgte_pkg::FUNC_EVAL;
    burst_left = 0;
    n_cfg = 0;
    n_stall = 0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: diode facing north, extra states off
    send_item(lgte_pkg::FUNC_EVAL, 8'h00);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_HIGH, lgte_pkg::ST_HIGH, lgte_pkg::ST_OFF, lgte_pkg::ST_OFF));
    send_item(lgte_pkg::FUNC_COMMIT, 8'hFF);
    send_item(lgte_pkg::FUNC_EVAL, 8'hFF);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_OFF, lgte_pkg::ST_OFF, lgte_pkg::ST_MID, lgte_pkg::ST_OFF));

    write_config(lgte_pkg::GATE_BUFFER, SIDE_EAST, 1'b1);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_HIGH, lgte_pkg::ST_OFF, lgte_pkg::ST_OFF, lgte_pkg::ST_HIGH));
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_OFF, lgte_pkg::ST_OFF, lgte_pkg::ST_LOW, lgte_pkg::ST_MID));
    send_item(lgte_pkg::FUNC_COMMIT, 8'h00);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_MID, lgte_pkg::ST_OFF, lgte_pkg::ST_OFF, lgte_pkg::ST_OFF));
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_HIGH, lgte_pkg::ST_LOW, lgte_pkg::ST_HIGH, lgte_pkg::ST_OFF));

    write_config(lgte_pkg::GATE_NOT, SIDE_WEST, 1'b1);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_HIGH, lgte_pkg::ST_HIGH, lgte_pkg::ST_OFF, lgte_pkg::ST_OFF));
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_OFF, lgte_pkg::ST_LOW, lgte_pkg::ST_MID, lgte_pkg::ST_OFF));
    send_item(lgte_pkg::FUNC_COMMIT, 8'hFF);

    write_config(GATE_UNUSED_MAX, SIDE_SOUTH, 1'b1);
    send_item(lgte_pkg::FUNC_EVAL, 8'h00);
    send_item(lgte_pkg::FUNC_COMMIT, 8'h00);

    write_config(lgte_pkg::GATE_XNOR, SIDE_NORTH, 1'b1);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_OFF, lgte_pkg::ST_MID, lgte_pkg::ST_HIGH, lgte_pkg::ST_OFF));
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_OFF, lgte_pkg::ST_HIGH, lgte_pkg::ST_HIGH, lgte_pkg::ST_HIGH));

    write_config(lgte_pkg::GATE_AND, SIDE_WEST, 1'b0);
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_HIGH, lgte_pkg::ST_HIGH, lgte_pkg::ST_HIGH, lgte_pkg::ST_LOW));
    send_item(lgte_pkg::FUNC_EVAL,
              pack_nbr(lgte_pkg::ST_HIGH, lgte_pkg::ST_MID, lgte_pkg::ST_OFF, lgte_pkg::ST_OFF));
    send_item(lgte_pkg::FUNC_COMMIT, 8'h00);
    s_axis_tvalid_i <= 1'b0;

    // Every gate kind with extra states off and on, output side rotating
    for (int k = lgte_pkg::GATE_DIODE; k <= lgte_pkg::GATE_XNOR; k++) begin
      for (int e = 0; e < 2; e++) begin
        write_config(4'(k), 2'((2 * k + e) % 4), 1'(e));
        if (k == lgte_pkg::GATE_NAND && e == 1) hold_req = 1'b1;  // back up the pipe once
        run_random(32);
      end
    end
    kind = 4'($urandom_range(lgte_pkg::GATE_XNOR + 1, GATE_UNUSED_MAX));
    write_config(kind, SIDE_WEST, 1'b1);
    run_random(16);

    wait_drained();
    $display("checked %0d transactions in and %0d results over %0d register settings",
             sb.n_in, sb.n_out, n_cfg);
    $display("input stalled %0d cycles under downstream back-pressure", n_stall);
    if (sb.n_err == 0 && sb.expected_q.size() == 0) begin
      $display("PASS logic_gate_tile_evaluator_core");
    end else begin
      $display("FAIL logic_gate_tile_evaluator_core");
    end
    $finish;
  end

endmodule
